// ===== design/srpc_pkg.sv =====
// ============================================================================
// srpc_pkg
// Shared types and constants of the stepper ramp parameter calculator.
// ============================================================================
`default_nettype none

package srpc_pkg;

    // Default values of the top level parameters.
    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_MAX_DIVISOR   = 13;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MICROSTEP_EXP   = 3'd0,
        REG_STEPS_PER_ROUND = 3'd1,
        REG_CLOCK_HZ        = 3'd2,
        REG_AUTO_DIVISORS   = 3'd3,
        REG_START_PULSE_DIV = 3'd4,
        REG_START_RAMP_DIV  = 3'd5
    } cfg_reg_t;

    // Register and state reset values.
    localparam logic [3:0]  RST_MICROSTEP_EXP   = 4'd6;
    localparam logic [12:0] RST_STEPS_PER_ROUND = 13'd200;
    localparam logic [26:0] RST_CLOCK_HZ        = 27'd16000000;
    localparam logic [3:0]  RST_PULSE_DIV       = 4'd6;
    localparam logic [3:0]  RST_RAMP_DIV        = 4'd7;
    localparam logic [11:0] RST_STORED_VEL      = 12'd200;
    localparam logic [10:0] RST_STORED_ACC      = 11'd200;

    // 1/(2*pi) scaled by 2^32.
    localparam logic [29:0] INV_TWO_PI = 30'd683565276;

    // Width of the scaled numerator |x| * steps * INV_TWO_PI.
    localparam int NUM_W = 75;
    // Divider remainder width (clock squared is below 2^54).
    localparam int REM_W = 54;
    // Raw quotient bits before rounding and the rounded saturation cap.
    localparam int QUO_W = 26;
    localparam logic [24:0] QUOT_CAP = 25'h1000000;

    // Search windows and controller limits.
    localparam logic [24:0] VEL_HIGH = 25'd2000;
    localparam logic [24:0] ACC_HIGH = 25'd2047;
    localparam logic [24:0] RAW_LOW  = 25'd50;
    localparam logic [4:0]  GAP_LIMIT = 5'd10;
    localparam int RAW_MAX = 2047;

    // One request: wanted velocity and acceleration.
    typedef struct packed {
        logic signed [31:0] velocity;
        logic signed [31:0] accel;
        logic               keep_velocity;
        logic               keep_accel;
    } in_t;

    // One result: raw controller values and divisors.
    typedef struct packed {
        logic signed [11:0] velocity_raw;
        logic [10:0]        accel_raw;
        logic [3:0]         pulse_divisor;
        logic [3:0]         ramp_divisor;
        logic               divisors_changed;
    } out_t;

endpackage

`default_nettype wire

// ===== design/stepper_ramp_parameter_calc_unit.sv =====
// ============================================================================
// stepper_ramp_parameter_calc_unit
// Converts wanted velocity and acceleration into raw motion controller units.
// ============================================================================
// Usage: a request on in_valid/in_ready carries a Q-format velocity and
// acceleration plus keep flags. Exactly one result follows on
// out_valid/out_ready. The user must write registers through cfg_wr_en,
// cfg_index and cfg_data only while the block is idle; nothing enforces it.
// Datapath: one shared 32x32 multiplier forms the squared clock and the
// scaled numerators, and a restoring divider produces one quotient bit per
// cycle. Each trial of a divisor divides a numerator of
// pd + microstep_exp + 60 - FRACTION_BITS bits for velocity and
// pd + rd + microstep_exp + 73 - FRACTION_BITS bits for acceleration.
// A keep flag skips its phase, and in auto mode every extra divisor step
// adds one more division.
// Throughput: one request at a time; in_ready is high only when idle.
// Reset: registers and stored divisors and raw values take their defaults.
// Stall: a result is held in the output register until taken, and no new
// request is accepted meanwhile.
// ============================================================================
`default_nettype none

module stepper_ramp_parameter_calc_unit #(
    parameter int FRACTION_BITS = srpc_pkg::DEF_FRACTION_BITS,
    parameter int MAX_DIVISOR   = srpc_pkg::DEF_MAX_DIVISOR
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire srpc_pkg::in_t                       in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output srpc_pkg::out_t                           out_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [srpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [srpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import srpc_pkg::*;

    localparam logic [3:0] MAXD = 4'(MAX_DIVISOR);
    localparam int ITER_MAX = 2 * MAX_DIVISOR + 4;
    localparam int ITER_W = $clog2(ITER_MAX);
    localparam int VEL_BASE = NUM_W - 31 + 16 - FRACTION_BITS;
    localparam int ACC_BASE = NUM_W - 31 + 29 - FRACTION_BITS;
    localparam int CNT_W = $clog2(45 + ACC_BASE + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FF     = 11'b00000000010,
        S_MAG    = 11'b00000000100,
        S_XLO    = 11'b00000001000,
        S_XHI    = 11'b00000010000,
        S_XADD   = 11'b00000100000,
        S_DSTART = 11'b00001000000,
        S_DIV    = 11'b00010000000,
        S_DECIDE = 11'b00100000000,
        S_FINISH = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [3:0]  microstep_exp_reg;
    logic [12:0] steps_per_round_reg;
    logic [26:0] clock_hz_reg;
    logic        auto_divisors_reg;

    // Persistent state.
    logic [3:0]         pulse_cur_reg;
    logic [3:0]         ramp_cur_reg;
    logic signed [11:0] stored_vel_reg;
    logic [10:0]        stored_acc_reg;

    // Working registers.
    in_t                   in_reg;
    logic                  phase_reg;
    logic [3:0]            pd_reg;
    logic [3:0]            rd_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic [53:0]           den2_reg;
    logic [63:0]           prod_reg;
    logic [44:0]           m_reg;
    logic [NUM_W-1:0]      x_reg;
    logic [NUM_W-1:0]      xs_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic                  ovf_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic signed [25:0]    vel_reg;
    logic [24:0]           acc_reg;
    out_t                  out_reg;
    logic                  out_valid_reg;

    // Magnitude of a signed 32-bit field.
    function automatic logic [31:0] mag_of(input logic signed [31:0] v);
        mag_of = v[31] ? (~v + 32'd1) : v;
    endfunction

    logic        in_fire;
    logic [26:0] fclk;
    logic [31:0] mag_sel;
    logic [31:0] mul_a, mul_b;
    logic [63:0] p_mul;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign fclk      = (clock_hz_reg == 27'd0) ? 27'd1 : clock_hz_reg;
    assign mag_sel   = phase_reg ? mag_of(in_reg.accel) : mag_of(in_reg.velocity);

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            S_FF:
            begin
                mul_a = {5'd0, fclk};
                mul_b = {5'd0, fclk};
            end
            S_MAG:
            begin
                mul_a = mag_sel;
                mul_b = {19'd0, steps_per_round_reg};
            end
            S_XLO:
            begin
                mul_a = {9'd0, prod_reg[22:0]};
                mul_b = {2'd0, INV_TWO_PI};
            end
            S_XHI:
            begin
                mul_a = {10'd0, m_reg[44:23]};
                mul_b = {2'd0, INV_TWO_PI};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign p_mul = mul_a * mul_b;

    // Divider step and operand setup.
    logic [REM_W-1:0] den_sel;
    logic [REM_W:0]   rem_shift;
    logic             rem_ge;
    logic [CNT_W-1:0] n_bits;

    assign den_sel   = phase_reg ? den2_reg : {27'd0, fclk};
    assign rem_shift = {rem_reg, xs_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_sel});
    assign n_bits    = phase_reg
        ? (CNT_W'(microstep_exp_reg) + CNT_W'(pd_reg) + CNT_W'(rd_reg) + CNT_W'(ACC_BASE))
        : (CNT_W'(microstep_exp_reg) + CNT_W'(pd_reg) + CNT_W'(VEL_BASE));

    // Round to nearest from the doubled quotient, with saturation.
    logic [26:0] quo_inc;
    logic [25:0] quo_half;
    logic [24:0] q_round;

    assign quo_inc  = {1'b0, quo_reg} + 27'd1;
    assign quo_half = quo_inc[26:1];
    assign q_round  = (ovf_reg || (quo_half > {1'b0, QUOT_CAP})) ? QUOT_CAP : quo_half[24:0];

    // Divisor search decisions.
    logic               vmag_nz;
    logic [3:0]         npd, nrd;
    logic signed [4:0]  gap_s;
    logic [4:0]         gap_abs;
    logic               last_iter;
    logic               search_done;
    logic signed [25:0] vel_trial;

    assign vmag_nz   = (in_reg.velocity != 32'sd0);
    assign gap_s     = $signed({1'b0, rd_reg}) - $signed({1'b0, pd_reg});
    assign gap_abs   = gap_s[4] ? 5'(-gap_s) : 5'(gap_s);
    assign last_iter = (iter_reg == ITER_W'(ITER_MAX - 1));
    assign vel_trial = in_reg.velocity[31] ? -$signed({1'b0, q_round})
                                           : $signed({1'b0, q_round});

    always_comb
    begin
        npd = pd_reg;
        if ((q_round > VEL_HIGH) && (pd_reg > 4'd0) && vmag_nz)
        begin
            npd = npd - 4'd1;
        end
        if ((q_round < RAW_LOW) && (pd_reg < MAXD) && vmag_nz)
        begin
            npd = npd + 4'd1;
        end
        nrd = rd_reg;
        if ((q_round > ACC_HIGH) && (rd_reg > 4'd0) && (gap_abs < GAP_LIMIT))
        begin
            nrd = nrd - 4'd1;
        end
        if ((q_round < RAW_LOW) && (rd_reg < MAXD) && (gap_abs < GAP_LIMIT))
        begin
            nrd = nrd + 4'd1;
        end
        if (phase_reg)
        begin
            search_done = (nrd == rd_reg) || !auto_divisors_reg || last_iter;
        end
        else
        begin
            search_done = (npd == pd_reg) || !auto_divisors_reg || last_iter;
        end
    end

    // Final limits on acceleration and velocity.
    logic signed [5:0]  d_s;
    logic signed [5:0]  dm1;
    logic signed [5:0]  dp12;
    logic [27:0]        acc_src;
    logic [27:0]        acc_lo_lim;
    logic [27:0]        acc_hi_lim;
    logic [27:0]        acc_a, acc_b;
    logic [10:0]        acc_fin;
    logic signed [25:0] vel_src;
    logic signed [11:0] vel_fin;

    assign d_s        = $signed({2'b0, rd_reg}) - $signed({2'b0, pd_reg});
    assign dm1        = d_s - 6'sd1;
    assign dp12       = d_s + 6'sd12;
    assign acc_src    = in_reg.keep_accel ? {17'd0, stored_acc_reg} : {3'd0, acc_reg};
    assign acc_lo_lim = 28'd1 << dm1[3:0];
    assign acc_hi_lim = (28'd1 << dp12[4:0]) - 28'd1;
    assign vel_src    = in_reg.keep_velocity ? 26'(stored_vel_reg) : vel_reg;

    always_comb
    begin
        acc_a = acc_src;
        if ((d_s >= 6'sd1) && (acc_a < acc_lo_lim))
        begin
            acc_a = acc_lo_lim;
        end
        if (dp12 <= 6'sd0)
        begin
            acc_b = 28'd0;
        end
        else if (acc_a > acc_hi_lim)
        begin
            acc_b = acc_hi_lim;
        end
        else
        begin
            acc_b = acc_a;
        end
        if (acc_b > 28'(RAW_MAX))
        begin
            acc_fin = 11'(RAW_MAX);
        end
        else if (acc_b == 28'd0)
        begin
            acc_fin = 11'd1;
        end
        else
        begin
            acc_fin = acc_b[10:0];
        end
        if (vel_src < -26'sd2047)
        begin
            vel_fin = -12'sd2047;
        end
        else if (vel_src > 26'sd2047)
        begin
            vel_fin = 12'sd2047;
        end
        else if (vel_src == 26'sd0)
        begin
            vel_fin = 12'sd1;
        end
        else
        begin
            vel_fin = vel_src[11:0];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_FF;
                end
            end
            S_FF:
            begin
                if (!in_reg.keep_velocity || !in_reg.keep_accel)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MAG:    state_next = S_XLO;
            S_XLO:    state_next = S_XHI;
            S_XHI:    state_next = S_XADD;
            S_XADD:   state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!search_done)
                begin
                    state_next = S_DSTART;
                end
                else if (!phase_reg && !in_reg.keep_accel)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and stored values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            out_valid_reg       <= 1'b0;
            microstep_exp_reg   <= RST_MICROSTEP_EXP;
            steps_per_round_reg <= RST_STEPS_PER_ROUND;
            clock_hz_reg        <= RST_CLOCK_HZ;
            auto_divisors_reg   <= 1'b0;
            pulse_cur_reg       <= RST_PULSE_DIV;
            ramp_cur_reg        <= RST_RAMP_DIV;
            stored_vel_reg      <= RST_STORED_VEL;
            stored_acc_reg      <= RST_STORED_ACC;
            phase_reg           <= 1'b0;
            iter_reg            <= '0;
            cnt_reg             <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MICROSTEP_EXP:   microstep_exp_reg   <= cfg_data[3:0];
                    REG_STEPS_PER_ROUND: steps_per_round_reg <= cfg_data[12:0];
                    REG_CLOCK_HZ:        clock_hz_reg        <= cfg_data[26:0];
                    REG_AUTO_DIVISORS:   auto_divisors_reg   <= cfg_data[0];
                    REG_START_PULSE_DIV:
                    begin
                        pulse_cur_reg <= (cfg_data[3:0] > MAXD) ? MAXD : cfg_data[3:0];
                    end
                    REG_START_RAMP_DIV:
                    begin
                        ramp_cur_reg <= (cfg_data[3:0] > MAXD) ? MAXD : cfg_data[3:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                phase_reg <= in_data.keep_velocity;
                iter_reg  <= '0;
            end

            if (state_reg == S_DSTART)
            begin
                cnt_reg <= n_bits;
            end
            else if ((state_reg == S_DIV) && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (state_reg == S_DECIDE)
            begin
                if (!search_done)
                begin
                    iter_reg <= iter_reg + ITER_W'(1);
                end
                else
                begin
                    phase_reg <= 1'b1;
                    iter_reg  <= '0;
                end
            end

            if (state_reg == S_FINISH)
            begin
                out_valid_reg  <= 1'b1;
                pulse_cur_reg  <= pd_reg;
                ramp_cur_reg   <= rd_reg;
                stored_vel_reg <= vel_fin;
                stored_acc_reg <= acc_fin;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= in_data;
            pd_reg <= pulse_cur_reg;
            rd_reg <= ramp_cur_reg;
        end

        unique case (state_reg)
            S_FF:
            begin
                den2_reg <= p_mul[53:0];
            end
            S_MAG:
            begin
                prod_reg <= p_mul;
            end
            S_XLO:
            begin
                m_reg    <= prod_reg[44:0];
                prod_reg <= p_mul;
            end
            S_XHI:
            begin
                x_reg    <= NUM_W'(prod_reg[52:0]);
                prod_reg <= p_mul;
            end
            S_XADD:
            begin
                x_reg <= x_reg + {prod_reg[51:0], 23'd0};
            end
            S_DSTART:
            begin
                xs_reg  <= x_reg;
                rem_reg <= '0;
                quo_reg <= '0;
                ovf_reg <= 1'b0;
            end
            S_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    xs_reg  <= {xs_reg[NUM_W-2:0], 1'b0};
                    rem_reg <= rem_ge ? REM_W'(rem_shift - {1'b0, den_sel})
                                      : rem_shift[REM_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
                    ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
                end
            end
            S_DECIDE:
            begin
                if (phase_reg)
                begin
                    acc_reg <= q_round;
                    if (!search_done)
                    begin
                        rd_reg <= nrd;
                    end
                end
                else
                begin
                    vel_reg <= vel_trial;
                    if (!search_done)
                    begin
                        pd_reg <= npd;
                    end
                end
            end
            S_FINISH:
            begin
                out_reg.velocity_raw     <= vel_fin;
                out_reg.accel_raw        <= acc_fin;
                out_reg.pulse_divisor    <= pd_reg;
                out_reg.ramp_divisor     <= rd_reg;
                out_reg.divisors_changed <= (pd_reg != pulse_cur_reg) ||
                                            (rd_reg != ramp_cur_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Checks on the sequencer and datapath.
    a_ready_excl_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request accepted while a result is pending");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("ready stayed high after a request was taken");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_sel))
        else $error("divider remainder not below divisor");

    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.accel_raw != 11'd0) && (out_data.velocity_raw != 12'sd0)))
        else $error("result raw value is zero");

endmodule

`default_nettype wire
